// File: rtl/block_median_filter_macros.svh
// Assertion macros shared by the median filter RTL.
// Depends on nothing; included by the controller and the datapath.
`ifndef BLOCK_MEDIAN_FILTER_MACROS_SVH
`define BLOCK_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BMF_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("median filter check failed");

// Next-cycle implication, disabled while reset is asserted
`define BMF_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("median filter check failed");

`endif

// File: rtl/blkmed_pkg.sv
// Shared types and constants for the decimating median filter.
// No dependencies; imported by the controller, the datapath and the top level.
package blkmed_pkg;

  localparam int CH_W  = 2;   // channel tag width
  localparam int SMP_W = 16;  // sample width, two's complement

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,   // taking items
    ST_READ,   // reading the stored window out of the RAM
    ST_DRAIN,  // last read word lands in the sorter
    ST_EMIT    // push the median into the output register
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic rd;        // issue one RAM read of the window
    logic load_out;  // load the median into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_hit;  // current item completes its channel's window
    logic rd_done;   // this read is the last one of the window
    logic out_free;  // output register can take a new result
  } dp_status_t;

endpackage

// File: rtl/blkmed_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module blkmed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/blkmed_ctrl.sv
// Controller state machine of the median filter.
// Depends on blkmed_pkg and block_median_filter_macros.svh.
`include "block_median_filter_macros.svh"

module blkmed_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  blkmed_pkg::dp_status_t status,
  output blkmed_pkg::ctrl_cmd_t  cmd
);

  import blkmed_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.last_hit) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (status.rd_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.rd       = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
      end
    endcase
  end

  `BMF_NEXT(a_start_read, clk, rst_n, cmd.take && status.last_hit, state_r == ST_READ)
  `BMF_NEXT(a_read_to_drain, clk, rst_n, state_r == ST_READ && status.rd_done, state_r == ST_DRAIN)

endmodule

// File: rtl/blkmed_dp.sv
// Datapath of the median filter: fill counters, sample RAM, insertion sorter
// and output register. Depends on blkmed_pkg, blkmed_ram and the macro header.
`include "block_median_filter_macros.svh"

module blkmed_dp #(
  parameter int WINDOW       = 11,
  parameter int NUM_CHANNELS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [blkmed_pkg::CH_W-1:0]         in_channel,
  input  logic signed [blkmed_pkg::SMP_W-1:0] in_sample,
  input  blkmed_pkg::ctrl_cmd_t               cmd,
  output blkmed_pkg::dp_status_t              status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [blkmed_pkg::CH_W-1:0]         out_channel,
  output logic signed [blkmed_pkg::SMP_W-1:0] out_median
);

  import blkmed_pkg::*;

  localparam int DEPTH = WINDOW * NUM_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(WINDOW);
  localparam int KW    = $clog2(WINDOW + 1);
  localparam int MID   = WINDOW / 2;

  // per-channel fill counters
  logic [CNT_W-1:0] fill_r   [NUM_CHANNELS];
  logic [CNT_W-1:0] fill_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0] cur_cnt;
  logic             ch_ok;
  logic             start;
  logic             we;
  logic [AW-1:0]    ch_base;
  logic [AW-1:0]    waddr;

  // window read-back
  logic [AW-1:0]    rd_base_r, rd_base_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r;
  logic [AW-1:0]    raddr;
  logic [SMP_W-1:0] rdata;

  // insertion sorter
  logic signed [SMP_W-1:0] srt_r   [WINDOW];
  logic signed [SMP_W-1:0] srt_nxt [WINDOW];
  logic [WINDOW-1:0]       gt;
  logic [KW-1:0]           ins_cnt_r, ins_cnt_nxt, k_eff;
  logic signed [SMP_W-1:0] ins_val;
  logic                    ins_en;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]         out_ch_r, ch_r;
  logic signed [SMP_W-1:0] out_med_r;

  // channel lookup
  assign ch_ok = int'(in_channel) < NUM_CHANNELS;

  always_comb begin
    cur_cnt = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (int'(in_channel) == i) begin
        cur_cnt = fill_r[i];
      end
    end
  end

  assign status.last_hit = ch_ok && (cur_cnt == CNT_W'(WINDOW - 1));
  assign start           = cmd.take && status.last_hit;
  assign we              = cmd.take && ch_ok && !status.last_hit;
  assign ch_base         = AW'(int'(in_channel) * WINDOW);
  assign waddr           = ch_base + AW'(cur_cnt);

  // fill counter update
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      fill_nxt[i] = fill_r[i];
      if (cmd.take && ch_ok && int'(in_channel) == i) begin
        fill_nxt[i] = status.last_hit ? '0 : cur_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // sample store
  blkmed_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read address sequencing
  always_comb begin
    rd_base_nxt = rd_base_r;
    rd_idx_nxt  = rd_idx_r;
    if (start) begin
      rd_base_nxt = ch_base;
      rd_idx_nxt  = '0;
    end else if (cmd.rd) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  assign raddr          = rd_base_r + AW'(rd_idx_r);
  assign status.rd_done = rd_idx_r == CNT_W'(WINDOW - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      rd_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_base_r <= rd_base_nxt;
    if (start) begin
      ch_r <= in_channel;
    end
  end

  // insertion: entries at or past the count act as +infinity
  assign ins_en  = start || rd_vld_r;
  assign ins_val = start ? in_sample : $signed(rdata);
  assign k_eff   = start ? '0 : ins_cnt_r;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      gt[i] = (int'(k_eff) <= i) || (srt_r[i] > ins_val);
    end
    srt_nxt[0] = gt[0] ? ins_val : srt_r[0];
    for (int i = 1; i < WINDOW; i++) begin
      if (!gt[i]) begin
        srt_nxt[i] = srt_r[i];
      end else if (!gt[i-1]) begin
        srt_nxt[i] = ins_val;
      end else begin
        srt_nxt[i] = srt_r[i-1];
      end
    end
    ins_cnt_nxt = k_eff + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      srt_r <= srt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_cnt_r <= '0;
    end else if (ins_en) begin
      ins_cnt_r <= ins_cnt_nxt;
    end
  end

  // output register
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch_r  <= ch_r;
      out_med_r <= srt_r[MID];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_median  = out_med_r;

  `BMF_IMPL(a_sort_full, clk, rst_n, cmd.load_out, ins_cnt_r == KW'(WINDOW))
  `BMF_NEXT(a_out_load, clk, rst_n, cmd.load_out, out_valid_r)

endmodule

// File: rtl/block_median_filter.sv
// Decimating median filter: one result per WINDOW samples of a channel.
// Item that does not complete a window: accepted, no result.
// Completing item: WINDOW-1 RAM reads feed the insertion sorter one word a
// cycle; the median then goes into the output register once that register is free.
// Next item is not taken until that median is loaded, so out_tready stalls can hold it off.
// Synchronous active-low reset clears fill counters, control and output valid.
module block_median_filter #(
  parameter int WINDOW       = 11,
  parameter int NUM_CHANNELS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [blkmed_pkg::SMP_W-1:0]  in_tdata,   // [15:0] sample
  input  logic [blkmed_pkg::CH_W-1:0]   in_tuser,   // [1:0] channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [blkmed_pkg::SMP_W-1:0]  out_tdata,  // [15:0] median
  output logic [blkmed_pkg::CH_W-1:0]   out_tuser   // [1:0] out_channel
);

  import blkmed_pkg::*;

  ctrl_cmd_t               cmd;
  dp_status_t              status;
  logic signed [SMP_W-1:0] median;

  blkmed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  blkmed_dp #(
    .WINDOW       (WINDOW),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_channel  (in_tuser),
    .in_sample   ($signed(in_tdata)),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_channel (out_tuser),
    .out_median  (median)
  );

  assign out_tdata = $unsigned(median);

endmodule
